@@ src/assert_macros.svh @@
// small set of concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/mlss_pkg.sv @@
`default_nettype none

package mlss_pkg;

  localparam int unsigned WEIGHT_W     = 32;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned SUM_W        = 64;
  localparam int unsigned LEVEL_BITS_W = 14;
  localparam int unsigned CATEGORY_W   = 5;
  localparam int unsigned DEF_WEIGHT_BITS = 32;

  localparam int unsigned NUM_LEVELS   = 9;
  localparam int unsigned NUM_BANKS    = 2;
  // entries per level: bank x {hit, miss}
  localparam int unsigned LANE_ENTRIES = 4;
  localparam int unsigned LANE_ADDR_W  = $clog2(LANE_ENTRIES);
  localparam int unsigned LEVEL_SEL_W  = $clog2(NUM_LEVELS);

  // level bit field positions
  localparam int unsigned BIT_NA   = 0;
  localparam int unsigned BIT_HIT  = 1;
  localparam int unsigned BIT_MISS = 2;

  // read categories beyond the per-level ones
  localparam logic [CATEGORY_W-1:0] CAT_LEVEL_END = CATEGORY_W'(2 * NUM_LEVELS);
  localparam logic [CATEGORY_W-1:0] CAT_TOTAL     = CATEGORY_W'(2 * NUM_LEVELS);
  localparam logic [CATEGORY_W-1:0] CAT_NA        = CATEGORY_W'(2 * NUM_LEVELS + 1);

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // which level bits flag each level (remote pairs share one level)
  localparam logic [LEVEL_BITS_W-1:0] LEVEL_MASK [NUM_LEVELS] = '{
    14'h0008,  // l1
    14'h0020,  // l2
    14'h0040,  // l3
    14'h0010,  // line fill buffer
    14'h0080,  // local ram
    14'h0300,  // remote ram
    14'h0C00,  // remote cache
    14'h1000,  // io
    14'h2000   // uncached
  };

  typedef struct packed {
    logic                    mode;
    logic                    access_kind;
    logic [LEVEL_BITS_W-1:0] level_bits;
    logic [WEIGHT_W-1:0]     weight;
    logic [CATEGORY_W-1:0]   category;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [WEIGHT_W-1:0] min_w;
    logic [WEIGHT_W-1:0] max_w;
    logic [SUM_W-1:0]    sum;
  } lane_stats_t;

  typedef struct packed {
    logic                   upd;
    logic [LANE_ADDR_W-1:0] addr;
    logic [WEIGHT_W-1:0]    weight;
  } lane_ctrl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (&c) ? c : c + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ src/mlss_in_if.sv @@
`default_nettype none

interface mlss_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic                                 access_kind;
  logic [mlss_pkg::LEVEL_BITS_W-1:0]    level_bits;
  logic [mlss_pkg::WEIGHT_W-1:0]        weight;
  logic [mlss_pkg::CATEGORY_W-1:0]      category;

  modport source (output valid, mode, access_kind, level_bits, weight, category,
                  input ready);
  modport sink   (input valid, mode, access_kind, level_bits, weight, category,
                  output ready);
endinterface

`default_nettype wire

@@ src/mlss_out_if.sv @@
`default_nettype none

interface mlss_out_if;
  logic                            valid;
  logic                            ready;
  logic [mlss_pkg::COUNT_W-1:0]    sample_count;
  logic [mlss_pkg::WEIGHT_W-1:0]   weight_min;
  logic [mlss_pkg::WEIGHT_W-1:0]   weight_max;
  logic [mlss_pkg::SUM_W-1:0]      weight_sum;

  modport source (output valid, sample_count, weight_min, weight_max, weight_sum,
                  input ready);
  modport sink   (input valid, sample_count, weight_min, weight_max, weight_sum,
                  output ready);
endinterface

`default_nettype wire

@@ src/mlss_level.sv @@
`default_nettype none

// counters of one memory level: bank x {hit, miss}
module mlss_level (
  input  logic                   clk,
  input  logic                   rst,
  input  mlss_pkg::lane_ctrl_t   ctrl,
  output mlss_pkg::lane_stats_t  stats
);
  import mlss_pkg::*;

  lane_stats_t entry [LANE_ENTRIES];
  lane_stats_t entry_next;

  assign stats = entry[ctrl.addr];

  always_comb begin
    entry_next.count = sat_inc(stats.count);
    entry_next.min_w = (ctrl.weight < stats.min_w) ? ctrl.weight : stats.min_w;
    entry_next.max_w = (ctrl.weight > stats.max_w) ? ctrl.weight : stats.max_w;
    entry_next.sum   = stats.sum + {{(SUM_W - WEIGHT_W){1'b0}}, ctrl.weight};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_ENTRIES; i++) begin
        entry[i].count <= '0;
        entry[i].min_w <= '1;
        entry[i].max_w <= '0;
        entry[i].sum   <= '0;
      end
    end else if (ctrl.upd) begin
      entry[ctrl.addr] <= entry_next;
    end
  end

endmodule

`default_nettype wire

@@ src/memory_level_sample_statistics_unit.sv @@
// channel  | dir | transaction
// ---------+-----+-------------------------------------------------------
// item     | in  | record a sample (mode 0) or read a category (mode 1)
// result   | out | counters of one category, one per read transaction
//
// one item per cycle sustained while result is not stalled: input register,
// one pass of add/compare logic per level, then the result register
// a read taken on item passes the input register, then the result register
// rst (synchronous) clears every counter; minimums reset to all ones
// a stalled result holds a read in the input register and the input behind it;
// records ahead of that read keep flowing
`default_nettype none
`include "assert_macros.svh"

module memory_level_sample_statistics_unit #(
  parameter int unsigned WEIGHT_BITS = mlss_pkg::DEF_WEIGHT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  mlss_in_if.sink    item,
  mlss_out_if.source result
);
  import mlss_pkg::*;

  // only the low WEIGHT_BITS of the weight count
  localparam int unsigned WEIGHT_USED = (WEIGHT_BITS > WEIGHT_W) ? WEIGHT_W : WEIGHT_BITS;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = {WEIGHT_W{1'b1}} >> (WEIGHT_W - WEIGHT_USED);

  // input register
  logic  s1_valid;
  item_t s1_item;
  logic  s1_go;

  // result register
  logic        out_valid;
  lane_stats_t out_data;
  lane_stats_t out_next;

  // bank-wide counters
  logic [COUNT_W-1:0] bank_samples  [NUM_BANKS];
  logic [SUM_W-1:0]   bank_wsum     [NUM_BANKS];
  logic [COUNT_W-1:0] unknown_count [NUM_BANKS];

  // per-level lanes
  lane_ctrl_t  lane_ctrl  [NUM_LEVELS];
  lane_stats_t lane_stats [NUM_LEVELS];

  logic                   bank;
  logic                   hit;
  logic                   miss;
  logic [WEIGHT_W-1:0]    w;
  logic [LEVEL_SEL_W-1:0] level_sel;

  assign bank      = s1_item.access_kind;
  assign hit       = s1_item.level_bits[BIT_HIT];
  assign miss      = s1_item.level_bits[BIT_MISS];
  assign w         = s1_item.weight & WEIGHT_MASK;
  assign level_sel = s1_item.category[CATEGORY_W-1:1];

  // a record always moves on; a read needs a free result register
  assign s1_go      = s1_valid && (s1_item.mode == MODE_RECORD || !out_valid || result.ready);
  assign item.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item.mode        <= item.mode;
      s1_item.access_kind <= item.access_kind;
      s1_item.level_bits  <= item.level_bits;
      s1_item.weight      <= item.weight;
      s1_item.category    <= item.category;
    end
  end

  // lane address: category low bit on reads, hit/miss choice on records
  genvar gl;
  generate
    for (gl = 0; gl < NUM_LEVELS; gl++) begin : g_level
      always_comb begin
        lane_ctrl[gl].upd    = s1_go && s1_item.mode == MODE_RECORD && (hit || miss)
                               && |(s1_item.level_bits & LEVEL_MASK[gl]);
        lane_ctrl[gl].addr   = (s1_item.mode == MODE_READ) ?
                               {bank, s1_item.category[0]} : {bank, !hit};
        lane_ctrl[gl].weight = w;
      end

      mlss_level u_level (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (lane_ctrl[gl]),
        .stats (lane_stats[gl])
      );
    end
  endgenerate

  // bank totals and not-available count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        bank_samples[b]  <= '0;
        bank_wsum[b]     <= '0;
        unknown_count[b] <= '0;
      end
    end else if (s1_go && s1_item.mode == MODE_RECORD) begin
      bank_samples[bank] <= sat_inc(bank_samples[bank]);
      bank_wsum[bank]    <= bank_wsum[bank] + {{(SUM_W - WEIGHT_W){1'b0}}, w};
      if (s1_item.level_bits[BIT_NA]) begin
        unknown_count[bank] <= sat_inc(unknown_count[bank]);
      end
    end
  end

  // read data select
  always_comb begin
    out_next = '0;
    priority if (s1_item.category < CAT_LEVEL_END) begin
      out_next = lane_stats[level_sel];
    end else if (s1_item.category == CAT_TOTAL) begin
      out_next.count = bank_samples[bank];
      out_next.sum   = bank_wsum[bank];
    end else if (s1_item.category == CAT_NA) begin
      out_next.count = unknown_count[bank];
    end else begin
      out_next = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_item.mode == MODE_READ) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.mode == MODE_READ) begin
      out_data <= out_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.sample_count = out_data.count;
  assign result.weight_min   = out_data.min_w;
  assign result.weight_max   = out_data.max_w;
  assign result.weight_sum   = out_data.sum;

  // a read held behind a stalled result keeps its place
  `ASSERT_NEXT(a_read_holds, clk, rst, s1_valid && s1_item.mode == MODE_READ && out_valid && !result.ready, s1_valid && $stable(s1_item))
  // every read that leaves the input register shows up as a result
  `ASSERT_NEXT(a_read_lands, clk, rst, s1_go && s1_item.mode == MODE_READ, out_valid)
  // not-available samples are a subset of all samples, saturation included
  `ASSERT_ALWAYS(a_na_le_total, clk, rst, unknown_count[0] <= bank_samples[0] && unknown_count[1] <= bank_samples[1])
  // an empty input register never back-pressures
  `ASSERT_IMPLIES(a_empty_ready, clk, rst, !s1_valid, item.ready)

endmodule

`default_nettype wire
